@@ rtl/zbh_pkg.sv @@
// Shared types, constants and helper functions for the Zobrist board hash.
package zbh_pkg;

  localparam int unsigned KeyCount   = 781;
  localparam int unsigned PieceKeys  = 768;
  localparam int unsigned SideBase   = 768;
  localparam int unsigned CastleBase = 769;
  localparam int unsigned EpBase     = 773;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned AddrW = 10;

  localparam logic [63:0] GenSeed = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] GenMult = 64'h2545F4914F6CDD1D;

  localparam logic [3:0] PieceNone = 4'd12;

  typedef logic [63:0] key_t;

  // xorshift64 state step, shifts 12 / 25 / 27
  function automatic key_t gen_step(input key_t s);
    key_t t;
    t = s ^ (s >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

  // piece letter to piece number, PieceNone for anything else
  function automatic logic [3:0] piece_number(input logic [7:0] ch);
    logic [3:0] p;
    case (ch)
      8'h50: p = 4'd0;   // P
      8'h4E: p = 4'd1;   // N
      8'h42: p = 4'd2;   // B
      8'h52: p = 4'd3;   // R
      8'h51: p = 4'd4;   // Q
      8'h4B: p = 4'd5;   // K
      8'h70: p = 4'd6;   // p
      8'h6E: p = 4'd7;   // n
      8'h62: p = 4'd8;   // b
      8'h72: p = 4'd9;   // r
      8'h71: p = 4'd10;  // q
      8'h6B: p = 4'd11;  // k
      default: p = PieceNone;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/zobrist_board_hash.sv @@
// Zobrist board hash: key store fill sequencer and one-square-per-cycle hash pipeline.
//
// After reset the block fills its key store from a xorshift64* generator, one key per
// cycle through a multiply with registered partial products; in_ready stays low
// until all 781 keys are stored. After that it takes one square word per cycle:
// the piece key is read from a 768 x 64 single-port memory with registered read data,
// and XORed into the accumulator in the next cycle. On the word marked last, the side,
// castle and en-passant keys (held in flops) are folded in and the hash is written to
// the output register as the word leaves the s1 stage. A waiting result stalls input
// only when another last word needs the output register.
module zobrist_board_hash
  import zbh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  square_row,
  input  logic [2:0]  square_col,
  input  logic [7:0]  piece_char,
  input  logic        last_square,
  input  logic        side_to_move,
  input  logic [3:0]  castle_rights,
  input  logic signed [3:0] en_passant_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  // ---------------- key fill ----------------
  key_t            gen;
  logic [IdxW-1:0] gen_cnt;
  logic            gen_go;
  key_t            gen_next;

  logic            a_valid;
  logic [IdxW-1:0] a_idx;
  logic [63:0]     a_ll;
  logic [31:0]     a_hl;
  logic [31:0]     a_lh;
  key_t            a_key;

  logic            filled;

  key_t            side_key;
  key_t            castle_key [4];
  key_t            ep_key [8];

  assign gen_go   = !filled && (gen_cnt != IdxW'(KeyCount));
  assign gen_next = gen_step(gen);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen     <= GenSeed;
      gen_cnt <= '0;
      a_valid <= 1'b0;
      filled  <= 1'b0;
    end else begin
      a_valid <= gen_go;
      if (gen_go) begin
        gen     <= gen_next;
        gen_cnt <= gen_cnt + IdxW'(1);
      end
      if (a_valid && a_idx == IdxW'(KeyCount - 1)) begin
        filled <= 1'b1;
      end
    end
  end

  // low 64 bits of gen_next * GenMult as three 32x32 partial products
  always_ff @(posedge clk) begin
    a_idx <= gen_cnt;
    a_ll  <= 64'(gen_next[31:0]) * 64'(GenMult[31:0]);
    a_hl  <= 32'(gen_next[63:32] * GenMult[31:0]);
    a_lh  <= 32'(gen_next[31:0] * GenMult[63:32]);
  end

  assign a_key = a_ll + {a_hl + a_lh, 32'd0};

  always_ff @(posedge clk) begin
    if (a_valid) begin
      if (a_idx == IdxW'(SideBase)) begin
        side_key <= a_key;
      end else if (a_idx >= IdxW'(CastleBase) && a_idx < IdxW'(EpBase)) begin
        castle_key[2'(a_idx - IdxW'(CastleBase))] <= a_key;
      end else if (a_idx >= IdxW'(EpBase)) begin
        ep_key[3'(a_idx - IdxW'(EpBase))] <= a_key;
      end
    end
  end

  // ---------------- hash pipeline ----------------
  key_t             piece_mem [PieceKeys];
  key_t             rd_data;
  logic             accept;
  logic [3:0]       in_piece;
  logic [AddrW-1:0] rd_addr;

  logic       s1_valid;
  logic       s1_hit;
  logic       s1_last;
  logic       s1_black;
  logic [3:0] s1_castle;
  logic [3:0] s1_ep;
  logic       s1_adv;

  key_t acc;
  key_t acc_next;
  key_t fold;

  assign in_piece = piece_number(piece_char);
  assign rd_addr  = {in_piece[3:0], square_row, square_col};
  assign s1_adv   = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = filled && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (a_valid && a_idx < IdxW'(PieceKeys)) begin
      piece_mem[a_idx] <= a_key;
    end
    if (accept && in_piece != PieceNone) begin
      rd_data <= piece_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit    <= (in_piece != PieceNone);
      s1_last   <= last_square;
      s1_black  <= side_to_move;
      s1_castle <= castle_rights;
      s1_ep     <= en_passant_col;
    end
  end

  always_comb begin
    acc_next = acc ^ (s1_hit ? rd_data : '0);
    fold = s1_black ? side_key : '0;
    for (int i = 0; i < 4; i++) begin
      if (s1_castle[i]) fold = fold ^ castle_key[i];
    end
    // sign bit set means no en-passant file
    if (!s1_ep[3]) fold = fold ^ ep_key[s1_ep[2:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        acc <= s1_last ? '0 : acc_next;
      end
      if (s1_adv && s1_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      hash_value <= acc_next ^ fold;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    gen_cnt <= IdxW'(KeyCount))
    else $error("fill counter ran past key count");

  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    filled |-> !a_valid && !gen_go)
    else $error("key fill still active after store marked full");

  a_s1_filled: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> filled)
    else $error("square word in flight before key store filled");

  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && out_valid && !out_ready |=> s1_valid && s1_last)
    else $error("last word dropped while output register full");

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> acc == '0)
    else $error("accumulator not cleared after last word");
`endif

endmodule

@@ sim/zobrist_hash_checker.sv @@
// Hash checker: watches both channels, predicts each position hash and compares.
module zobrist_hash_checker
  import zbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        square_row,
  input  logic [2:0]        square_col,
  input  logic [7:0]        piece_char,
  input  logic              last_square,
  input  logic              side_to_move,
  input  logic [3:0]        castle_rights,
  input  logic signed [3:0] en_passant_col,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [63:0]       hash_value,
  output int unsigned       mismatch_count,
  output int unsigned       hashes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam string PieceSet  = "PNBRQKpnbrqk";
  localparam int    MaxReport = 10;

  key_t        key_table [KeyCount];
  key_t        running_hash;
  key_t        hashes_due [$];
  key_t        position_hash;
  key_t        hash_wanted;
  logic [3:0]  piece_idx;

  // piece letter to table plane, PieceNone when the byte is not a piece
  function automatic logic [3:0] plane_of(input logic [7:0] ch);
    for (int i = 0; i < 12; i++) begin
      if (PieceSet[i] == ch) return 4'(i);
    end
    return PieceNone;
  endfunction

  // xorshift64* key sequence, same order as the block's fill
  initial begin
    key_t gen;
    gen = GenSeed;
    for (int i = 0; i < KeyCount; i++) begin
      gen = gen ^ (gen >> 12);
      gen = gen ^ (gen << 25);
      gen = gen ^ (gen >> 27);
      key_table[i] = gen * GenMult;
    end
    mismatch_count = 0;
    hashes_pending = 0;
    running_hash = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      running_hash = '0;
      hashes_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        piece_idx = plane_of(piece_char);
        if (piece_idx != PieceNone) begin
          running_hash ^= key_table[int'(piece_idx) * 64 + int'(square_row) * 8
                                    + int'(square_col)];
        end
        if (last_square) begin
          position_hash = running_hash;
          if (side_to_move) position_hash ^= key_table[SideBase];
          for (int b = 0; b < 4; b++) begin
            if (castle_rights[b]) position_hash ^= key_table[CastleBase + b];
          end
          // sign bit set means no en-passant file
          if (!en_passant_col[3]) begin
            position_hash ^= key_table[EpBase + int'(en_passant_col[2:0])];
          end
          hashes_due.push_back(position_hash);
          running_hash = '0;
        end
      end
      if (out_valid && out_ready) begin
        if (hashes_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReport)
            $display("hash word with none expected: got %h", hash_value);
        end else begin
          hash_wanted = hashes_due.pop_front();
          if (hash_value !== hash_wanted) begin
            mismatch_count++;
            if (mismatch_count <= MaxReport)
              $display("hash_value mismatch: expected %h, got %h", hash_wanted, hash_value);
          end
        end
      end
    end
    hashes_pending = hashes_due.size();
  end

endmodule

@@ sim/tb_zobrist_board_hash.sv @@
// Testbench top for the Zobrist board hash: clock, reset, square stimulus and verdict.
module tb_zobrist_board_hash;
  timeunit 1ns;
  timeprecision 1ps;

  localparam string       PieceSet   = "PNBRQKpnbrqk";
  localparam logic [7:0]  EmptyChar  = 8'h2E;  // '.'
  localparam logic [3:0]  CastleNone = 4'h0;
  localparam logic [3:0]  CastleAll  = 4'hF;
  localparam logic [3:0]  EpNone     = 4'hF;   // -1
  localparam logic [3:0]  EpMostNeg  = 4'h8;   // -8
  localparam int          ItemTarget = 1250;
  localparam int          HoldCycles = 400;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        square_row;
  logic [2:0]        square_col;
  logic [7:0]        piece_char;
  logic              last_square;
  logic              side_to_move;
  logic [3:0]        castle_rights;
  logic signed [3:0] en_passant_col;
  logic              out_valid;
  logic              out_ready;
  logic [63:0]       hash_value;

  int unsigned mismatch_count;
  int unsigned hashes_pending;
  int unsigned items_sent;
  bit          tx_steady;
  bit          long_hold;

  zobrist_board_hash uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .square_row     (square_row),
    .square_col     (square_col),
    .piece_char     (piece_char),
    .last_square    (last_square),
    .side_to_move   (side_to_move),
    .castle_rights  (castle_rights),
    .en_passant_col (en_passant_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hash_value     (hash_value)
  );

  zobrist_hash_checker hash_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .square_row     (square_row),
    .square_col     (square_col),
    .piece_char     (piece_char),
    .last_square    (last_square),
    .side_to_move   (side_to_move),
    .castle_rights  (castle_rights),
    .en_passant_col (en_passant_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hash_value     (hash_value),
    .mismatch_count (mismatch_count),
    .hashes_pending (hashes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return EmptyChar;
    if (r < 85) return PieceSet[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [3:0] random_ep();
    if ($urandom_range(0, 9) < 6) return 4'($urandom_range(0, 7));
    return 4'($urandom_range(8, 15));
  endfunction

  task automatic send_square(input logic [2:0] row, input logic [2:0] col,
                             input logic [7:0] ch, input logic last,
                             input logic side, input logic [3:0] castle,
                             input logic [3:0] ep);
    int unsigned gap;
    square_row     <= row;
    square_col     <= col;
    piece_char     <= ch;
    last_square    <= last;
    side_to_move   <= side;
    castle_rights  <= castle;
    en_passant_col <= ep;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // position of n squares; scan walks the board in order, else squares are random
  task automatic play_position(input int n, input bit scan);
    for (int k = 0; k < n; k++) begin
      send_square(scan ? 3'((k / 8) % 8) : 3'($urandom_range(0, 7)),
                  scan ? 3'(k % 8) : 3'($urandom_range(0, 7)),
                  random_char(), k == n - 1, 1'($urandom_range(0, 1)),
                  4'($urandom_range(0, 15)), random_ep());
    end
  endtask

  // receiver: random stalls, steady stretches, and one long hold on request
  initial begin
    int unsigned stall_left;
    int unsigned phase_left;
    bit          rx_steady;
    int unsigned n;
    stall_left = 0;
    phase_left = 0;
    rx_steady  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        rx_steady  = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(50, 250);
      end else begin
        phase_left--;
      end
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        long_hold = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        n = idle_len();
        out_ready <= (n == 0);
        if (n > 0) stall_left = n - 1;
      end
    end
  end

  initial begin
    int unsigned r;
    items_sent = 0;
    tx_steady  = 1'b0;
    long_hold  = 1'b0;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    square_row     <= '0;
    square_col     <= '0;
    piece_char     <= EmptyChar;
    last_square    <= 1'b0;
    side_to_move   <= 1'b0;
    castle_rights  <= CastleNone;
    en_passant_col <= EpNone;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty board, no flags: hash of nothing
    send_square(3'd0, 3'd0, EmptyChar, 1'b1, 1'b0, CastleNone, EpNone);
    // corner squares, every flag set
    send_square(3'd0, 3'd0, "P", 1'b0, 1'b0, CastleNone, EpNone);
    send_square(3'd7, 3'd7, "k", 1'b1, 1'b1, CastleAll, 4'd7);
    // each piece once; flags on the non-last words must be ignored
    for (int i = 0; i < 12; i++) begin
      send_square(3'(i % 8), 3'(7 - i % 8), PieceSet[i], i == 11, 1'b1, CastleAll, 4'd3);
    end
    // non-piece bytes add nothing, most negative en-passant column is none
    send_square(3'd2, 3'd5, 8'hFF, 1'b0, 1'b0, CastleNone, 4'd0);
    send_square(3'd3, 3'd4, 8'h00, 1'b0, 1'b0, CastleNone, 4'd0);
    send_square(3'd4, 3'd3, EmptyChar, 1'b0, 1'b0, CastleNone, 4'd0);
    send_square(3'd5, 3'd2, "x", 1'b0, 1'b0, CastleNone, 4'd0);
    send_square(3'd6, 3'd1, 8'h80, 1'b1, 1'b1, 4'hA, EpMostNeg);
    send_square(3'd1, 3'd6, "Q", 1'b1, 1'b0, 4'h5, 4'd0);

    // receiver holds off while short positions pile up behind the result
    long_hold = 1'b1;
    tx_steady = 1'b1;
    repeat (30) play_position($urandom_range(1, 2), 1'b0);

    while (items_sent < ItemTarget) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 65)      play_position($urandom_range(1, 8), 1'b0);
      else if (r < 88) play_position($urandom_range(9, 40), 1'b0);
      else if (r < 96) play_position(64, 1'b1);
      else             play_position($urandom_range(65, 100), 1'b0);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (hashes_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && hashes_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ zobrist_board_hash.f @@
rtl/zbh_pkg.sv
rtl/zobrist_board_hash.sv
sim/zobrist_hash_checker.sv
sim/tb_zobrist_board_hash.sv
